[rtl/core/bsa_pkg.sv]
// Package for the bitmap slot allocator: field widths, codes, state encoding,
// the request and response records of the shared arithmetic unit, and a bit search helper.
// No dependencies.
package bsa_pkg;

    // Field and register widths
    localparam int OFFSET_W   = 20;
    localparam int SIZE_W     = 13;
    localparam int BYTES_W    = 6;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int STATUS_W   = 2;

    // Iteration counts of the shared arithmetic unit
    localparam int DIV_STEPS = OFFSET_W;
    localparam int MUL_STEPS = SIZE_W;
    localparam int ACNT_W    = 5;

    // Map byte constants
    localparam logic [7:0] FULL_BYTE = 8'hFF;
    localparam logic [7:0] TOP_BIT   = 8'h80;

    // Reset values of the configuration registers
    localparam logic [BYTES_W-1:0] BYTES_RESET = 6'd32;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE    = 1'b1;

    // Request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        AOP_MUL = 1'b0,
        AOP_DIV = 1'b1
    } arith_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL,
        S_DIV,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic                start;
        arith_op_t           op;
        logic [OFFSET_W-1:0] a;
        logic [SIZE_W-1:0]   b;
    } arith_req_t;

    // Response from the shared arithmetic unit
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [OFFSET_W-1:0] result;
    } arith_resp_t;

    // Position of the most significant clear bit, counted from bit 7 down.
    function automatic logic [2:0] first_free(input logic [7:0] map_byte);
        logic [2:0] pos;
        logic       found;
        pos   = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && !map_byte[7-i])
            begin
                pos   = 3'(i);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

[rtl/core/bitmap_slot_allocator_unit.sv]
// Bitmap slot allocator, first fit. An allocate transaction scans the occupancy
// map one byte per cycle from byte 0 and then multiplies the slot number by the slot
// size in the shared arithmetic unit; a full map reports no free slot once all n
// bytes in use have been scanned. A free transaction divides the offset by the
// slot size in the same unit (20 steps), clears the bit when the slot is in range,
// then scans the n bytes in use to report whether the map is empty, stopping early
// at the first nonzero byte. One transaction is worked on at a time, through the
// single arithmetic unit and the single map read port, and a finished result waits
// in the output register while the next one is taken. The map is empty straight
// after reset.
module bitmap_slot_allocator_unit #(
    parameter int MAX_MAP_BYTES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // [19:0] free_offset
    input  logic                              s_tuser,   // [0] operation
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [19:0] slot_offset, [20] all_free
    output logic [bsa_pkg::STATUS_W-1:0]      m_tuser,   // [1:0] status
    // Configuration writes
    input  logic                              cfg_wen,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int BW = (MAX_MAP_BYTES > 1) ? $clog2(MAX_MAP_BYTES) : 1;
    localparam int SW = BW + 3;
    localparam int NW = $clog2(MAX_MAP_BYTES + 1);

    // Configuration registers
    logic [bsa_pkg::BYTES_W-1:0]  bitmap_bytes_reg;
    logic [bsa_pkg::SIZE_W-1:0]   slot_size_reg;

    // Sequencer registers
    bsa_pkg::state_t              state_reg, state_next;
    logic [NW-1:0]                idx_reg, idx_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic                         is_free_reg, is_free_next;
    bsa_pkg::status_t             status_reg, status_next;
    logic [bsa_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                         all_free_reg, all_free_next;

    // Output register
    logic                         out_valid_reg;
    bsa_pkg::status_t             out_status_reg;
    logic [bsa_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                         out_all_free_reg;
    logic                         load_out;

    // Derived values
    logic [8:0]                   bytes_ext;
    logic [8:0]                   bytes_cap;
    logic [NW-1:0]                n_bytes;
    logic [NW+2:0]                slot_limit;
    logic [bsa_pkg::SIZE_W-1:0]   size_eff;
    logic [NW-1:0]                idx_inc;
    logic [2:0]                   free_bit;
    logic [SW-1:0]                found_slot;

    // Map and arithmetic unit connections
    logic [BW-1:0]                map_rd_addr;
    logic [7:0]                   map_rd_data;
    logic                         map_wr_en;
    logic [BW-1:0]                map_wr_addr;
    logic [7:0]                   map_wr_data;
    bsa_pkg::arith_req_t          arith_req;
    bsa_pkg::arith_resp_t         arith_resp;

    bsa_map #(
        .DEPTH (MAX_MAP_BYTES),
        .AW    (BW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    bsa_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .resp  (arith_resp)
    );

    // Configuration registers take every write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_bytes_reg <= bsa_pkg::BYTES_RESET;
            slot_size_reg    <= bsa_pkg::SIZE_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                bsa_pkg::REG_BITMAP_BYTES: bitmap_bytes_reg <= cfg_wdata[bsa_pkg::BYTES_W-1:0];
                bsa_pkg::REG_SLOT_SIZE:    slot_size_reg    <= cfg_wdata;
            endcase
        end
    end

    // Bytes in use are capped at the map depth; a zero slot size counts as one.
    always_comb
    begin
        bytes_ext  = 9'(bitmap_bytes_reg);
        bytes_cap  = (bytes_ext > 9'(MAX_MAP_BYTES)) ? 9'(MAX_MAP_BYTES) : bytes_ext;
        n_bytes    = bytes_cap[NW-1:0];
        slot_limit = {n_bytes, 3'b000};
        size_eff   = (slot_size_reg == '0) ? bsa_pkg::SIZE_W'(1) : slot_size_reg;
        idx_inc    = idx_reg + NW'(1);
        free_bit   = bsa_pkg::first_free(map_rd_data);
        found_slot = {idx_reg[BW-1:0], free_bit};
    end

    // Sequencer state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bsa_pkg::S_IDLE;
            is_free_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_free_reg <= is_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        offset_reg   <= offset_next;
        all_free_reg <= all_free_next;
    end

    // Next state, map accesses and arithmetic requests
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        is_free_next  = is_free_reg;
        status_next   = status_reg;
        offset_next   = offset_reg;
        all_free_next = all_free_reg;
        map_rd_addr   = idx_reg[BW-1:0];
        map_wr_en     = 1'b0;
        map_wr_addr   = idx_reg[BW-1:0];
        map_wr_data   = map_rd_data;
        arith_req     = '0;
        load_out      = 1'b0;

        unique case (state_reg)
            bsa_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next      = '0;
                    offset_next   = '0;
                    all_free_next = 1'b0;
                    status_next   = bsa_pkg::ST_OK;
                    if (s_tuser == bsa_pkg::OP_ALLOC)
                    begin
                        is_free_next = 1'b0;
                        if (n_bytes == '0)
                        begin
                            status_next = bsa_pkg::ST_FULL;
                            state_next  = bsa_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = bsa_pkg::S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        is_free_next    = 1'b1;
                        arith_req.start = 1'b1;
                        arith_req.op    = bsa_pkg::AOP_DIV;
                        arith_req.a     = s_tdata[bsa_pkg::OFFSET_W-1:0];
                        arith_req.b     = size_eff;
                        state_next      = bsa_pkg::S_DIV;
                    end
                end
            end

            bsa_pkg::S_SCAN_RD:
            begin
                state_next = bsa_pkg::S_SCAN_CHK;
            end

            // One map byte per cycle; the read of the next byte overlaps the check.
            bsa_pkg::S_SCAN_CHK:
            begin
                if (!is_free_reg && map_rd_data != bsa_pkg::FULL_BYTE)
                begin
                    map_wr_en       = 1'b1;
                    map_wr_data     = map_rd_data | (bsa_pkg::TOP_BIT >> free_bit);
                    arith_req.start = 1'b1;
                    arith_req.op    = bsa_pkg::AOP_MUL;
                    arith_req.a     = bsa_pkg::OFFSET_W'(found_slot);
                    arith_req.b     = size_eff;
                    state_next      = bsa_pkg::S_MUL;
                end
                else if (is_free_reg && map_rd_data != 8'h00)
                begin
                    all_free_next = 1'b0;
                    state_next    = bsa_pkg::S_DONE;
                end
                else if (idx_inc < n_bytes)
                begin
                    idx_next    = idx_inc;
                    map_rd_addr = idx_inc[BW-1:0];
                end
                else
                begin
                    if (is_free_reg)
                    begin
                        all_free_next = 1'b1;
                    end
                    else
                    begin
                        status_next = bsa_pkg::ST_FULL;
                    end
                    state_next = bsa_pkg::S_DONE;
                end
            end

            bsa_pkg::S_MUL:
            begin
                if (arith_resp.done)
                begin
                    offset_next = arith_resp.result;
                    state_next  = bsa_pkg::S_DONE;
                end
            end

            // Quotient is the slot number; check it against the slots in use.
            bsa_pkg::S_DIV:
            begin
                if (arith_resp.done)
                begin
                    idx_next = '0;
                    if (arith_resp.result >= bsa_pkg::OFFSET_W'(slot_limit))
                    begin
                        status_next = bsa_pkg::ST_RANGE;
                        if (n_bytes == '0)
                        begin
                            all_free_next = 1'b1;
                            state_next    = bsa_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = bsa_pkg::S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        slot_next  = arith_resp.result[SW-1:0];
                        state_next = bsa_pkg::S_FREE_RD;
                    end
                end
            end

            bsa_pkg::S_FREE_RD:
            begin
                map_rd_addr = slot_reg[SW-1:3];
                state_next  = bsa_pkg::S_FREE_WR;
            end

            bsa_pkg::S_FREE_WR:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = slot_reg[SW-1:3];
                map_wr_data = map_rd_data & ~(bsa_pkg::TOP_BIT >> slot_reg[2:0]);
                state_next  = bsa_pkg::S_SCAN_RD;
            end

            bsa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = bsa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bsa_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg   <= status_reg;
            out_offset_reg   <= offset_reg;
            out_all_free_reg <= all_free_reg;
        end
    end

    assign s_tready = (state_reg == bsa_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_all_free_reg, out_offset_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // An accepted transaction always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != bsa_pkg::S_IDLE))
    else $error("request accepted but sequencer stayed idle");

    // The shared unit is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.start |-> !arith_resp.busy)
    else $error("arithmetic unit started while busy");

    // The map is written only when a slot is taken or released.
    assert property (@(posedge clk) disable iff (!rst_n)
        map_wr_en |-> (state_reg == bsa_pkg::S_SCAN_CHK || state_reg == bsa_pkg::S_FREE_WR))
    else $error("map written outside allocate or free");

    // An out-of-range free never carries an offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == bsa_pkg::ST_RANGE) |-> (m_tdata[19:0] == 20'd0))
    else $error("range error with nonzero offset");

    // A full-map result comes from an allocate and never reports an empty map.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == bsa_pkg::ST_FULL) |-> !m_tdata[20])
    else $error("no-free-slot result with all_free set");
`endif

endmodule

[rtl/core/bsa_map.sv]
// Occupancy map storage: one write port and one registered read port, with a
// valid bit per byte so that reset empties the map at once. Depends on nothing.
module bsa_map #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    // Storage array and registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits: a byte never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

[rtl/core/bsa_arith.sv]
// Shared iterative arithmetic unit: restoring division and shift-add
// multiplication, one step per cycle through a single adder. Depends on bsa_pkg.
module bsa_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  bsa_pkg::arith_req_t  req,
    output bsa_pkg::arith_resp_t resp
);

    bsa_pkg::arith_op_t                op_reg;
    logic [bsa_pkg::OFFSET_W-1:0]      acc_reg;
    logic [bsa_pkg::OFFSET_W-1:0]      quo_reg;
    logic [bsa_pkg::OFFSET_W-1:0]      opnd_reg;
    logic [bsa_pkg::SIZE_W-1:0]        mult_reg;
    logic [bsa_pkg::ACNT_W-1:0]        cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [bsa_pkg::OFFSET_W-1:0]      rem_sh;
    logic [bsa_pkg::OFFSET_W-1:0]      add_x;
    logic [bsa_pkg::OFFSET_W-1:0]      add_y;
    logic                              add_cin;
    logic [bsa_pkg::OFFSET_W:0]        sum;
    logic                              carry;
    logic                              last_step;

    // One adder serves both operations. For division it subtracts the divisor
    // from the shifted remainder; the carry out says the subtraction fits.
    always_comb
    begin
        rem_sh = {acc_reg[bsa_pkg::OFFSET_W-2:0], quo_reg[bsa_pkg::OFFSET_W-1]};
        if (op_reg == bsa_pkg::AOP_DIV)
        begin
            add_x   = rem_sh;
            add_y   = ~opnd_reg;
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {acc_reg[bsa_pkg::OFFSET_W-2:0], 1'b0};
            add_y   = mult_reg[bsa_pkg::SIZE_W-1] ? opnd_reg : '0;
            add_cin = 1'b0;
        end
        sum   = {1'b0, add_x} + {1'b0, add_y} + (bsa_pkg::OFFSET_W+1)'(add_cin);
        carry = sum[bsa_pkg::OFFSET_W];
    end

    assign last_step = busy_reg && (cnt_reg == bsa_pkg::ACNT_W'(1));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg   <= req.op;
            acc_reg  <= '0;
            quo_reg  <= req.a;
            mult_reg <= req.b;
            if (req.op == bsa_pkg::AOP_DIV)
            begin
                opnd_reg <= bsa_pkg::OFFSET_W'(req.b);
            end
            else
            begin
                opnd_reg <= req.a;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == bsa_pkg::AOP_DIV)
            begin
                acc_reg <= carry ? sum[bsa_pkg::OFFSET_W-1:0] : rem_sh;
                quo_reg <= {quo_reg[bsa_pkg::OFFSET_W-2:0], carry};
            end
            else
            begin
                acc_reg  <= sum[bsa_pkg::OFFSET_W-1:0];
                mult_reg <= {mult_reg[bsa_pkg::SIZE_W-2:0], 1'b0};
            end
        end
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                if (req.op == bsa_pkg::AOP_DIV)
                begin
                    cnt_reg <= bsa_pkg::ACNT_W'(bsa_pkg::DIV_STEPS);
                end
                else
                begin
                    cnt_reg <= bsa_pkg::ACNT_W'(bsa_pkg::MUL_STEPS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - bsa_pkg::ACNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign resp.busy   = busy_reg;
    assign resp.done   = done_reg;
    assign resp.result = (op_reg == bsa_pkg::AOP_DIV) ? quo_reg : acc_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_slot_allocator_unit. It runs directed and random
// allocate and free transactions and checks each result against a behavioural map
// model or a result typed into the row. Depends on bsa_pkg and the allocator RTL.
module tb_top;
    import bsa_pkg::*;

    localparam int MAP_CAPACITY    = 32;
    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 80;    // comfortably beyond the slowest transaction
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_PRINTED     = 100;
    localparam int DIRECTED_ROWS   = 29;
    localparam int PHASES          = 9;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] slot_offset;
        logic                all_free;
    } slot_result_t;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_CHECKED,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic                 op;
        logic [OFFSET_W-1:0]  value;
        status_t              status;
        logic [OFFSET_W-1:0]  slot_offset;
        logic                 all_free;
    } directed_row_t;

    typedef struct {
        int map_bytes;      // -1 picks a small random map
        int slot_size;      // -1 picks a random size
        int idle_pct;
        int stall_pct;
        int items;
        int alloc_pct;
        bit hold_off;
        bit pause;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Model state: the occupancy map and the two registers
    logic [7:0]         occupancy [MAP_CAPACITY];
    logic [BYTES_W-1:0] cfg_map_bytes;
    logic [SIZE_W-1:0]  cfg_slot_size;

    slot_result_t pending_results [$];
    int           mismatch_count;
    int           quiet_cycles;
    int           request_idle_pct;
    int           ready_stall_pct;
    bit           hold_off_request;

    // Directed rows: reset state, extremes, empty map, zero slot size, full map,
    // unaligned free, freeing a free slot, map size above the capacity.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_OK,    20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_ALLOC, 20'hFFFFF, ST_OK,    20'd16, 1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'd16,    ST_OK,    20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'd16,    ST_OK,    20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'd0,     ST_OK,    20'd0,  1'b1},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'hFFFFF, ST_RANGE, 20'd0,  1'b1},
        '{ROW_CONFIG,  REG_BITMAP_BYTES, OP_ALLOC, 20'd0,     ST_OK,    20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_FULL,  20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'd0,     ST_RANGE, 20'd0,  1'b1},
        '{ROW_CONFIG,  REG_BITMAP_BYTES, OP_ALLOC, 20'd1,     ST_OK,    20'd0,  1'b0},
        '{ROW_CONFIG,  REG_SLOT_SIZE,    OP_ALLOC, 20'd0,     ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h5A5A5, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'hA5A5A, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'hFFFFF, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h0F0F0, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'hF0F0F, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h33333, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'hCCCCC, ST_OK,    20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_FULL,  20'd0,  1'b0},
        '{ROW_TYPED,   REG_BITMAP_BYTES, OP_FREE,  20'd8,     ST_RANGE, 20'd0,  1'b0},
        '{ROW_CONFIG,  REG_SLOT_SIZE,    OP_ALLOC, 20'd4096,  ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_FREE,  20'd4196,  ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_OK,    20'd0,  1'b0},
        '{ROW_CONFIG,  REG_BITMAP_BYTES, OP_ALLOC, 20'd63,    ST_OK,    20'd0,  1'b0},
        '{ROW_CONFIG,  REG_SLOT_SIZE,    OP_ALLOC, 20'd8191,  ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_ALLOC, 20'h00000, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_FREE,  20'hFFFFF, ST_OK,    20'd0,  1'b0},
        '{ROW_CHECKED, REG_BITMAP_BYTES, OP_FREE,  20'h00000, ST_OK,    20'd0,  1'b0}
    };

    // Random phases: map size, slot size, idling, length, share of allocations.
    // The large-size phase allocates past slot 128 so that offsets wrap.
    phase_t phases [PHASES] = '{
        '{2,  16,   0,  0,  150, 55, 1'b0, 1'b0},
        '{1,  1,    81, 0,  150, 55, 1'b0, 1'b0},
        '{4,  4096, 0,  81, 150, 60, 1'b0, 1'b0},
        '{32, 8191, 9,  9,  260, 92, 1'b0, 1'b0},
        '{0,  0,    0,  0,  40,  50, 1'b0, 1'b0},
        '{63, 5,    9,  9,  160, 45, 1'b0, 1'b0},
        '{-1, -1,   0,  0,  150, 55, 1'b1, 1'b0},
        '{2,  -1,   81, 0,  130, 55, 1'b0, 1'b1},
        '{-1, -1,   0,  81, 130, 55, 1'b0, 1'b0}
    };

    bitmap_slot_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [19:0] free_offset
        .s_tuser   (s_tuser),      // [0] operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [19:0] slot_offset, [20] all_free
        .m_tuser   (m_tuser),      // [1:0] status
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Map bytes actually in use, clamped to the capacity.
    function automatic int map_bytes_in_use();
        return (int'(cfg_map_bytes) > MAP_CAPACITY) ? MAP_CAPACITY : int'(cfg_map_bytes);
    endfunction

    // Slot size in bytes, with zero taken as one.
    function automatic int slot_bytes();
        return (cfg_slot_size == '0) ? 1 : int'(cfg_slot_size);
    endfunction

    // Works out the result of one transaction and updates the occupancy map.
    task automatic compute_slot_result(input logic op, input logic [OFFSET_W-1:0] offset,
                                       output slot_result_t res);
        int n;
        int sz;
        int pos;
        int slot;
        bit found;
        n = map_bytes_in_use();
        sz = slot_bytes();
        res.status = ST_OK;
        res.slot_offset = '0;
        res.all_free = 1'b0;
        if (op == OP_ALLOC)
        begin
            // First byte that is not full, then its most significant clear bit
            found = 1'b0;
            for (int i = 0; i < n && !found; i++)
            begin
                if (occupancy[i] != FULL_BYTE)
                begin
                    pos = 0;
                    while (occupancy[i][7 - pos])
                        pos++;
                    occupancy[i][7 - pos] = 1'b1;
                    res.slot_offset = OFFSET_W'((i * 8 + pos) * sz);
                    found = 1'b1;
                end
            end
            if (!found)
                res.status = ST_FULL;
        end
        else
        begin
            slot = int'(offset) / sz;
            if (slot >= n * 8)
                res.status = ST_RANGE;
            else
                occupancy[slot / 8][7 - slot % 8] = 1'b0;
            res.all_free = 1'b1;
            for (int i = 0; i < n; i++)
                if (occupancy[i] != '0)
                    res.all_free = 1'b0;
        end
    endtask

    // Mostly frees slots that are held, sometimes unaligned; the rest are random
    // slots of the map, arbitrary offsets and offsets past the end of the map.
    function automatic logic [OFFSET_W-1:0] choose_free_offset();
        int n;
        int sz;
        int pick;
        int slot;
        int held [$];
        n = map_bytes_in_use();
        sz = slot_bytes();
        for (int s = 0; s < n * 8; s++)
            if (occupancy[s / 8][7 - s % 8])
                held.push_back(s);
        pick = $urandom_range(99);
        if (pick < 65 && held.size() != 0)
        begin
            slot = held[$urandom_range(held.size() - 1)];
            if (pick < 45)
                return OFFSET_W'(slot * sz);
            return OFFSET_W'(slot * sz + int'($urandom_range(sz - 1)));
        end
        if (pick < 80 && n != 0)
            return OFFSET_W'(int'($urandom_range(n * 8 - 1)) * sz);
        if (pick < 90)
            return OFFSET_W'($urandom);
        return OFFSET_W'((n * 8 + int'($urandom_range(15))) * sz);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // Printing is capped so that a broken block cannot flood the log.
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Offers one request transaction and records its expected result on acceptance.
    task automatic send_request(input logic op, input logic [OFFSET_W-1:0] offset,
                                input bit typed, input slot_result_t typed_result);
        slot_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < request_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(24 - OFFSET_W){1'b0}}, offset};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        compute_slot_result(op, offset, predicted);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Stops offering requests and waits until every expected result has come.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_wen <= 1'b0;
        if (idx == REG_BITMAP_BYTES)
            cfg_map_bytes = BYTES_W'(value);
        else
            cfg_slot_size = SIZE_W'(value);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: status %0d offset 0x%05h",
                                          m_tuser, m_tdata[OFFSET_W-1:0]));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                if (m_tdata[OFFSET_W-1:0] !== want.slot_offset)
                    report_mismatch($sformatf("slot_offset 0x%05h, expected 0x%05h",
                                              m_tdata[OFFSET_W-1:0], want.slot_offset));
                if (m_tdata[OFFSET_W] !== want.all_free)
                    report_mismatch($sformatf("all_free %0b, expected %0b",
                                              m_tdata[OFFSET_W], want.all_free));
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bitmap_slot_allocator_unit verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then the random phases.
    initial
    begin
        slot_result_t typed_result;
        phase_t       ph;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        request_idle_pct = 0;
        ready_stall_pct = 0;
        hold_off_request = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        typed_result = '0;
        for (int i = 0; i < MAP_CAPACITY; i++)
            occupancy[i] = '0;
        cfg_map_bytes = BYTES_RESET;
        cfg_slot_size = SIZE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
                write_register(directed_rows[r].reg_index, int'(directed_rows[r].value));
            else
            begin
                typed_result = '{directed_rows[r].status, directed_rows[r].slot_offset,
                                 directed_rows[r].all_free};
                send_request(directed_rows[r].op, directed_rows[r].value,
                             directed_rows[r].kind == ROW_TYPED, typed_result);
            end
        end

        // Random part
        for (int p = 0; p < PHASES; p++)
        begin
            ph = phases[p];
            write_register(REG_BITMAP_BYTES,
                           (ph.map_bytes < 0) ? int'($urandom_range(8, 1)) : ph.map_bytes);
            write_register(REG_SLOT_SIZE,
                           (ph.slot_size < 0) ? int'($urandom_range(8191)) : ph.slot_size);
            request_idle_pct = ph.idle_pct;
            ready_stall_pct = ph.stall_pct;
            for (int k = 0; k < ph.items; k++)
            begin
                // Long receiver hold-off while requests keep coming, so the block backs up
                if (ph.hold_off && k == 20)
                    hold_off_request = 1'b1;
                // Sender pause until the block has delivered everything
                if (ph.pause && k == ph.items / 2)
                    drain_results();
                if ($urandom_range(99) < ph.alloc_pct)
                    send_request(OP_ALLOC, OFFSET_W'($urandom), 1'b0, typed_result);
                else
                    send_request(OP_FREE, choose_free_offset(), 1'b0, typed_result);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("bitmap_slot_allocator_unit verification clean");
        else
            $display("bitmap_slot_allocator_unit verification failed");
        $finish;
    end

endmodule
